>>> rtl/tgi_pkg.sv
package tgi_pkg;

  localparam int AXIS_POINTS_DEF = 16;
  localparam int FRAC_BITS       = 12;
  localparam int VALUE_BITS      = 24;
  localparam int COORD_BITS      = 16;
  localparam int INT_BITS        = COORD_BITS - FRAC_BITS;
  localparam int IDX_BITS        = 4;
  localparam int SIZE_BITS       = 5;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CHK_BITS        = 8;

  // datapath widths: weights span 0..2^FRAC_BITS
  localparam int W_BITS     = FRAC_BITS + 1;
  localparam int C_BITS     = VALUE_BITS + FRAC_BITS + 1;
  localparam int D_BITS     = VALUE_BITS + 2 * FRAC_BITS + 1;
  localparam int A_BITS     = D_BITS - FRAC_BITS;
  localparam int HI_BITS    = D_BITS;
  localparam int LO_BITS    = 2 * FRAC_BITS + 1;
  localparam int ROUND_BITS = 3 * FRAC_BITS + 1;
  localparam int T_BITS     = HI_BITS + 1;

  localparam logic [W_BITS-1:0]    W_ONE      = W_BITS'(1) << FRAC_BITS;
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(16);

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_RANGE  = 2'd1,
    STATUS_STORED = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_RESULT
  } seq_state_e;

  typedef struct packed {
    logic [W_BITS-1:0] wx0;
    logic [W_BITS-1:0] wx1;
    logic [W_BITS-1:0] wy0;
    logic [W_BITS-1:0] wy1;
    logic [W_BITS-1:0] wz0;
    logic [W_BITS-1:0] wz1;
  } weights_t;

  // corner bit 0: x+1, bit 1: y+1, bit 2: z+1
  typedef struct packed {
    logic       valid;
    logic [2:0] corner;
  } rd_tag_t;

  typedef struct packed {
    logic                  valid;
    logic [VALUE_BITS-1:0] value;
    status_e               status;
  } result_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] x;
    logic [SIZE_BITS-1:0] y;
    logic [SIZE_BITS-1:0] z;
  } sizes_t;

endpackage

>>> rtl/tgi_if.sv
interface tgi_req_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   mode;
  logic [tgi_pkg::IDX_BITS-1:0]           grid_x;
  logic [tgi_pkg::IDX_BITS-1:0]           grid_y;
  logic [tgi_pkg::IDX_BITS-1:0]           grid_z;
  logic signed [tgi_pkg::VALUE_BITS-1:0]  sample;
  logic [tgi_pkg::COORD_BITS-1:0]         coord_x;
  logic [tgi_pkg::COORD_BITS-1:0]         coord_y;
  logic [tgi_pkg::COORD_BITS-1:0]         coord_z;

  modport source (output valid, mode, grid_x, grid_y, grid_z, sample,
                  coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, mode, grid_x, grid_y, grid_z, sample,
                  coord_x, coord_y, coord_z, output ready);
endinterface

interface tgi_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [tgi_pkg::VALUE_BITS-1:0]  value;
  logic [1:0]                             status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

interface tgi_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tgi_pkg::CFG_IDX_BITS-1:0]   index;
  logic [tgi_pkg::SIZE_BITS-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/tgi_grid_mem.sv
module tgi_grid_mem #(
  parameter int ADDR_BITS = 12
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [ADDR_BITS-1:0]                  waddr_i,
  input  logic signed [tgi_pkg::VALUE_BITS-1:0] wdata_i,
  input  logic                                  re_i,
  input  logic [ADDR_BITS-1:0]                  raddr_i,
  output logic signed [tgi_pkg::VALUE_BITS-1:0] rdata_o
);
  import tgi_pkg::*;

  localparam int DEPTH = 1 << ADDR_BITS;

  logic signed [VALUE_BITS-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/tgi_lerp_pipe.sv
module tgi_lerp_pipe (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tgi_pkg::rd_tag_t                      rd_tag_i,
  input  logic signed [tgi_pkg::VALUE_BITS-1:0] rd_data_i,
  input  tgi_pkg::weights_t                     weights_i,
  output logic                                  res_valid_o,
  output logic [tgi_pkg::VALUE_BITS-1:0]        res_value_o
);
  import tgi_pkg::*;

  localparam logic [ROUND_BITS-1:0] HALF = ROUND_BITS'(1) << (3 * FRAC_BITS - 1);
  localparam int SH_BITS = ROUND_BITS - FRAC_BITS;

  rd_tag_t t0_q, t1_q;

  logic signed [C_BITS-1:0] p1_q, acc_c_q, c_q;
  logic                     c_v_q;
  logic [1:0]               c_tag_q;

  logic signed [D_BITS-1:0] p2_q, acc_d_q, d_q;
  logic                     p2_v_q, d_v_q;
  logic [1:0]               p2_tag_q;
  logic                     d_tag_q;

  logic signed [HI_BITS-1:0] ph_q, acc_hi_q, hi_q;
  logic [LO_BITS-1:0]        pl_q, acc_lo_q, lo_q;
  logic                      p3_v_q, p3_tag_q, s_v_q;

  logic                  res_v_q;
  logic [VALUE_BITS-1:0] res_value_q;

  logic [W_BITS-1:0]                 wx, wy, wz;
  logic signed [VALUE_BITS+W_BITS:0] prod1;
  logic signed [C_BITS+W_BITS:0]     prod2;
  logic signed [A_BITS-1:0]          a_w;
  logic [FRAC_BITS-1:0]              b_w;
  logic signed [A_BITS+W_BITS:0]     prod_hi;
  logic [LO_BITS-1:0]                prod_lo;
  logic [ROUND_BITS-1:0]             rnd;
  logic signed [T_BITS-1:0]          t_w;

  always_comb begin
    wx      = t0_q.corner[0] ? weights_i.wx1 : weights_i.wx0;
    wy      = c_tag_q[0] ? weights_i.wy1 : weights_i.wy0;
    wz      = d_tag_q ? weights_i.wz1 : weights_i.wz0;
    prod1   = rd_data_i * $signed({1'b0, wx});
    prod2   = c_q * $signed({1'b0, wy});
    a_w     = d_q[D_BITS-1:FRAC_BITS];
    b_w     = d_q[FRAC_BITS-1:0];
    prod_hi = a_w * $signed({1'b0, wz});
    prod_lo = LO_BITS'(b_w) * LO_BITS'(wz);
    // z split into a*S + b: low part carries the rounding half, then feeds the high part
    rnd     = ROUND_BITS'(lo_q) + HALF;
    t_w     = T_BITS'(hi_q) + $signed({{(T_BITS - SH_BITS){1'b0}},
                                       rnd[ROUND_BITS-1:FRAC_BITS]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_q    <= '0;
      t1_q    <= '0;
      c_v_q   <= 1'b0;
      p2_v_q  <= 1'b0;
      d_v_q   <= 1'b0;
      p3_v_q  <= 1'b0;
      s_v_q   <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      t0_q    <= rd_tag_i;
      t1_q    <= t0_q;
      c_v_q   <= t1_q.valid && t1_q.corner[0];
      p2_v_q  <= c_v_q;
      d_v_q   <= p2_v_q && p2_tag_q[0];
      p3_v_q  <= d_v_q;
      s_v_q   <= p3_v_q && p3_tag_q;
      res_v_q <= s_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // x pass
    if (t0_q.valid) begin
      p1_q <= prod1[C_BITS-1:0];
    end
    if (t1_q.valid && !t1_q.corner[0]) begin
      acc_c_q <= p1_q;
    end
    if (t1_q.valid && t1_q.corner[0]) begin
      c_q     <= acc_c_q + p1_q;
      c_tag_q <= t1_q.corner[2:1];
    end
    // y pass
    if (c_v_q) begin
      p2_q     <= prod2[D_BITS-1:0];
      p2_tag_q <= c_tag_q;
    end
    if (p2_v_q && !p2_tag_q[0]) begin
      acc_d_q <= p2_q;
    end
    if (p2_v_q && p2_tag_q[0]) begin
      d_q     <= acc_d_q + p2_q;
      d_tag_q <= p2_tag_q[1];
    end
    // z pass
    if (d_v_q) begin
      ph_q     <= prod_hi[HI_BITS-1:0];
      pl_q     <= prod_lo;
      p3_tag_q <= d_tag_q;
    end
    if (p3_v_q && !p3_tag_q) begin
      acc_hi_q <= ph_q;
      acc_lo_q <= pl_q;
    end
    if (p3_v_q && p3_tag_q) begin
      hi_q <= acc_hi_q + ph_q;
      lo_q <= acc_lo_q + pl_q;
    end
    if (s_v_q) begin
      res_value_q <= t_w[2*FRAC_BITS +: VALUE_BITS];
    end
  end

  assign res_valid_o = res_v_q;
  assign res_value_o = res_value_q;

endmodule

>>> rtl/tgi_seq.sv
module tgi_seq #(
  parameter int AXIS_POINTS = tgi_pkg::AXIS_POINTS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  tgi_req_if.sink                                req_i,
  input  tgi_pkg::sizes_t                        sizes_i,
  output logic                                   we_o,
  output logic [3*$clog2(AXIS_POINTS)-1:0]       waddr_o,
  output logic                                   re_o,
  output logic [3*$clog2(AXIS_POINTS)-1:0]       raddr_o,
  output tgi_pkg::rd_tag_t                       rd_tag_o,
  output tgi_pkg::weights_t                      weights_o,
  input  logic                                   pipe_valid_i,
  input  logic [tgi_pkg::VALUE_BITS-1:0]         pipe_value_i,
  output tgi_pkg::result_t                       result_o,
  input  logic                                   take_i
);
  import tgi_pkg::*;

  localparam int AW = $clog2(AXIS_POINTS);
  localparam logic [CHK_BITS-1:0] POINTS = CHK_BITS'(AXIS_POINTS);

  function automatic logic [CHK_BITS-1:0] limit_of(logic [SIZE_BITS-1:0] s);
    logic [CHK_BITS-1:0] e;
    e = CHK_BITS'(s);
    return (e < POINTS) ? e : POINTS;
  endfunction

  seq_state_e state_q, state_d;
  logic [2:0]            k_q;
  logic [AW-1:0]         bx_q, by_q, bz_q;
  weights_t              weights_q;
  logic [VALUE_BITS-1:0] value_q;
  status_e               status_q;

  logic                  accept, is_query, oor, load_ok;
  logic [INT_BITS-1:0]   xi, yi, zi;
  logic [CHK_BITS-1:0]   xe, ye, ze, gxe, gye, gze;
  logic [FRAC_BITS-1:0]  fx, fy, fz;

  always_comb begin
    xi  = req_i.coord_x[COORD_BITS-1:FRAC_BITS];
    yi  = req_i.coord_y[COORD_BITS-1:FRAC_BITS];
    zi  = req_i.coord_z[COORD_BITS-1:FRAC_BITS];
    fx  = req_i.coord_x[FRAC_BITS-1:0];
    fy  = req_i.coord_y[FRAC_BITS-1:0];
    fz  = req_i.coord_z[FRAC_BITS-1:0];
    xe  = CHK_BITS'(xi);
    ye  = CHK_BITS'(yi);
    ze  = CHK_BITS'(zi);
    gxe = CHK_BITS'(req_i.grid_x);
    gye = CHK_BITS'(req_i.grid_y);
    gze = CHK_BITS'(req_i.grid_z);
    // upper corner must sit inside both the configured size and the store
    oor = (xe + CHK_BITS'(1) >= limit_of(sizes_i.x)) ||
          (ye + CHK_BITS'(1) >= limit_of(sizes_i.y)) ||
          (ze + CHK_BITS'(1) >= limit_of(sizes_i.z));
    load_ok = (gxe < POINTS) && (gye < POINTS) && (gze < POINTS);
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign is_query    = (req_i.mode == MODE_QUERY);

  assign we_o    = accept && !is_query && load_ok;
  assign waddr_o = {gze[AW-1:0], gye[AW-1:0], gxe[AW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_READ) begin
        k_q <= k_q + 3'd1;
      end else begin
        k_q <= '0;
      end
    end
  end

  always_comb begin
    state_d         = state_q;
    re_o            = 1'b0;
    raddr_o         = {bz_q + AW'(k_q[2]), by_q + AW'(k_q[1]), bx_q + AW'(k_q[0])};
    rd_tag_o.valid  = 1'b0;
    rd_tag_o.corner = k_q;
    result_o.valid  = 1'b0;
    result_o.value  = value_q;
    result_o.status = status_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (is_query && !oor) ? ST_READ : ST_RESULT;
        end
      end
      ST_READ: begin
        re_o           = 1'b1;
        rd_tag_o.valid = 1'b1;
        if (k_q == 3'd7) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (pipe_valid_i) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        result_o.valid = 1'b1;
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q <= '0;
      if (!is_query) begin
        status_q <= STATUS_STORED;
      end else if (oor) begin
        status_q <= STATUS_RANGE;
      end else begin
        status_q      <= STATUS_OK;
        bx_q          <= xe[AW-1:0];
        by_q          <= ye[AW-1:0];
        bz_q          <= ze[AW-1:0];
        weights_q.wx1 <= W_BITS'(fx);
        weights_q.wx0 <= W_ONE - W_BITS'(fx);
        weights_q.wy1 <= W_BITS'(fy);
        weights_q.wy0 <= W_ONE - W_BITS'(fy);
        weights_q.wz1 <= W_BITS'(fz);
        weights_q.wz0 <= W_ONE - W_BITS'(fz);
      end
    end else if (state_q == ST_WAIT && pipe_valid_i) begin
      value_q <= pipe_value_i;
    end
  end

  assign weights_o = weights_q;

endmodule

>>> rtl/trilinear_grid_interpolator.sv
// Trilinear grid interpolator.
// req_i carries one request per handshake: mode 0 stores sample at
// (grid_x, grid_y, grid_z); mode 1 interpolates at (coord_x, coord_y, coord_z),
// unsigned with FRAC_BITS fraction bits. rsp_o returns one result per request:
// value and status (ok, out of range, stored). cfg_i writes size_x, size_y and
// size_z by index and is always ready; write it only while the block is idle.
// Requests are handled one at a time. A load, or a query rejected as out of
// range, goes from acceptance straight to the result state.
// An accepted query reads its eight corners from the grid memory's read port,
// one a cycle, then runs them through the x, y and z blend stages.
// The output register holds one result; while the receiver stalls the block
// finishes the request in hand, then holds it and stops taking requests.
// Reset sets all sizes to 16 and empties the output; grid contents are not
// cleared and must be loaded before they are queried.
module trilinear_grid_interpolator #(
  parameter int AXIS_POINTS = tgi_pkg::AXIS_POINTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tgi_req_if.sink    req_i,
  tgi_rsp_if.source  rsp_o,
  tgi_cfg_if.sink    cfg_i
);
  import tgi_pkg::*;

  localparam int ADDR_BITS = 3 * $clog2(AXIS_POINTS);

  sizes_t  sizes_q;
  result_t result;
  rd_tag_t rd_tag;
  weights_t weights;

  logic                         we, re, take, pipe_valid;
  logic [ADDR_BITS-1:0]         waddr, raddr;
  logic signed [VALUE_BITS-1:0] rdata;
  logic [VALUE_BITS-1:0]        pipe_value;

  logic                  rsp_valid_q;
  logic [VALUE_BITS-1:0] rsp_value_q;
  status_e               rsp_status_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sizes_q.x <= SIZE_RESET;
      sizes_q.y <= SIZE_RESET;
      sizes_q.z <= SIZE_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_SIZE_X: sizes_q.x <= cfg_i.data;
        CFG_SIZE_Y: sizes_q.y <= cfg_i.data;
        CFG_SIZE_Z: sizes_q.z <= cfg_i.data;
        default: ;
      endcase
    end
  end

  tgi_seq #(
    .AXIS_POINTS(AXIS_POINTS)
  ) u_seq (
    .clk_i,
    .rst_ni,
    .req_i,
    .sizes_i      (sizes_q),
    .we_o         (we),
    .waddr_o      (waddr),
    .re_o         (re),
    .raddr_o      (raddr),
    .rd_tag_o     (rd_tag),
    .weights_o    (weights),
    .pipe_valid_i (pipe_valid),
    .pipe_value_i (pipe_value),
    .result_o     (result),
    .take_i       (take)
  );

  tgi_grid_mem #(
    .ADDR_BITS(ADDR_BITS)
  ) u_mem (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (req_i.sample),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  tgi_lerp_pipe u_pipe (
    .clk_i,
    .rst_ni,
    .rd_tag_i    (rd_tag),
    .rd_data_i   (rdata),
    .weights_i   (weights),
    .res_valid_o (pipe_valid),
    .res_value_o (pipe_value)
  );

  assign take = !rsp_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (take) begin
      rsp_valid_q <= result.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && result.valid) begin
      rsp_value_q  <= result.value;
      rsp_status_q <= result.status;
    end
  end

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.value  = rsp_value_q;
  assign rsp_o.status = rsp_status_q;

endmodule
